[design/bge_pkg.sv]
package bge_pkg;

   // button slots carried by one poll
   localparam int SLOTS = 4;
   localparam int SLOT_W = 2;
   localparam int NUM_BUTTONS_DEF = 4;

   // field widths
   localparam int STATES_W = 8;
   localparam int TICK_W = 32;
   localparam int THR_W = 16;
   localparam int KIND_W = 3;
   localparam int FEAT_W = 7;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   // feature enable bit positions
   localparam int FE_COMBO = 0;
   localparam int FE_LCOMBO = 1;
   localparam int FE_DOUBLE = 2;
   localparam int FE_SHORT = 3;
   localparam int FE_LONG = 4;
   localparam int FE_REPEAT = 5;
   localparam int FE_RELEASE = 6;

   // event kinds
   localparam logic [KIND_W-1:0] EV_SHORT = 3'd0;
   localparam logic [KIND_W-1:0] EV_LONG = 3'd1;
   localparam logic [KIND_W-1:0] EV_REPEAT = 3'd2;
   localparam logic [KIND_W-1:0] EV_RELEASE = 3'd3;
   localparam logic [KIND_W-1:0] EV_COMBO = 3'd4;
   localparam logic [KIND_W-1:0] EV_LCOMBO = 3'd5;
   localparam logic [KIND_W-1:0] EV_DOUBLE = 3'd6;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FEATURES = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_FIRST = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_PERIOD = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DOUBLE_CLICK = 3'd4;

   // register reset values
   localparam logic [FEAT_W-1:0] FEATURES_RST = 7'd24;
   localparam logic [THR_W-1:0] LONG_PRESS_RST = 16'd800;
   localparam logic [THR_W-1:0] REPEAT_FIRST_RST = 16'd500;
   localparam logic [THR_W-1:0] REPEAT_PERIOD_RST = 16'd200;
   localparam logic [THR_W-1:0] DOUBLE_CLICK_RST = 16'd300;

   typedef enum logic [1:0] {
      BTN_IDLE      = 2'd0,
      BTN_PRESSING  = 2'd1,
      BTN_HELD      = 2'd2,
      BTN_RELEASING = 2'd3
   } btn_state_type;

   typedef enum logic [1:0] {
      CMP_LT,
      CMP_GE,
      CMP_GT
   } cmp_op_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_SCAN,
      SEQ_FLUSH
   } seq_state_type;

   typedef struct packed {
      logic [FEAT_W-1:0] feature_enables;
      logic [THR_W-1:0]  long_press_ticks;
      logic [THR_W-1:0]  repeat_first_ticks;
      logic [THR_W-1:0]  repeat_period_ticks;
      logic [THR_W-1:0]  double_click_ticks;
   } bge_cfg_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [SLOT_W-1:0] button;
      logic [SLOTS-1:0]  mask;
   } bge_event_type;

   typedef struct packed {
      logic          push;
      logic          finish;
      bge_event_type ev;
   } bge_emit_type;

endpackage

[design/bge_req_if.sv]
interface bge_req_if;
   logic                          valid;
   logic                          ready;
   logic [bge_pkg::STATES_W-1:0]  button_states;
   logic [bge_pkg::TICK_W-1:0]    now_ticks;

   modport source (output valid, output button_states, output now_ticks, input ready);
   modport sink (input valid, input button_states, input now_ticks, output ready);
endinterface

[design/bge_rsp_if.sv]
interface bge_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [bge_pkg::KIND_W-1:0]  event_kind;
   logic [bge_pkg::SLOT_W-1:0]  button_index;
   logic [bge_pkg::SLOTS-1:0]   combo_mask;
   logic                        last_of_poll;

   modport source (output valid, output event_kind, output button_index,
                   output combo_mask, output last_of_poll, input ready);
   modport sink (input valid, input event_kind, input button_index,
                 input combo_mask, input last_of_poll, output ready);
endinterface

[design/bge_tmr.sv]
module bge_tmr (
   input  logic [bge_pkg::TICK_W-1:0] now,
   input  logic [bge_pkg::TICK_W-1:0] stamp,
   input  logic [bge_pkg::THR_W-1:0]  thr,
   input  bge_pkg::cmp_op_type        op,
   output logic                       hit
);

   logic [bge_pkg::TICK_W-1:0] elapsed;
   logic [bge_pkg::TICK_W-1:0] thr_wide;

   // wrapping elapsed time against a zero-extended threshold
   assign elapsed = now - stamp;
   assign thr_wide = {{(bge_pkg::TICK_W - bge_pkg::THR_W){1'b0}}, thr};

   always_comb begin
      unique case (op)
         bge_pkg::CMP_LT: hit = elapsed < thr_wide;
         bge_pkg::CMP_GE: hit = elapsed >= thr_wide;
         bge_pkg::CMP_GT: hit = elapsed > thr_wide;
         default:         hit = 1'b0;
      endcase
   end

endmodule

[design/bge_out.sv]
module bge_out (
   input  logic                  clock,
   input  logic                  reset,
   input  bge_pkg::bge_emit_type emit,
   output logic                  grant,
   bge_rsp_if.source             rsp_ch
);

   logic                   pend_vld_ff, pend_vld_in;
   bge_pkg::bge_event_type pend_ff, pend_in;
   logic                   out_vld_ff, out_vld_in;
   bge_pkg::bge_event_type out_ff, out_in;
   logic                   out_last_ff, out_last_in;
   logic                   out_free;
   logic                   load;

   // one event is held back until the next one or the end of the poll
   assign out_free = !out_vld_ff || rsp_ch.ready;
   assign grant = !pend_vld_ff || out_free;
   assign load = (emit.push || emit.finish) && grant && pend_vld_ff;

   always_comb begin
      pend_vld_in = pend_vld_ff;
      pend_in = pend_ff;
      out_in = out_ff;
      out_last_in = out_last_ff;
      out_vld_in = rsp_ch.ready ? 1'b0 : out_vld_ff;
      if (load) begin
         out_in = pend_ff;
         out_last_in = emit.finish;
         out_vld_in = 1'b1;
      end
      if (emit.push && grant) begin
         pend_in = emit.ev;
         pend_vld_in = 1'b1;
      end else if (emit.finish && grant) begin
         pend_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         pend_vld_ff <= pend_vld_in;
         out_vld_ff <= out_vld_in;
      end
      pend_ff <= pend_in;
      out_ff <= out_in;
      out_last_ff <= out_last_in;
   end

   // result beat
   assign rsp_ch.valid = out_vld_ff;
   assign rsp_ch.event_kind = out_ff.kind;
   assign rsp_ch.button_index = out_ff.button;
   assign rsp_ch.combo_mask = out_ff.mask;
   assign rsp_ch.last_of_poll = out_last_ff;

endmodule

[design/bge_seq.sv]
module bge_seq #(
   parameter int NUM_BUTTONS = bge_pkg::NUM_BUTTONS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bge_pkg::bge_cfg_type  cfg,
   bge_req_if.sink               req_ch,
   input  logic                  grant,
   output bge_pkg::bge_emit_type emit
);

   localparam int Slots = bge_pkg::SLOTS;
   localparam int SlotW = bge_pkg::SLOT_W;
   localparam int ActiveButtons = (NUM_BUTTONS < Slots) ? NUM_BUTTONS : Slots;
   localparam logic [SlotW-1:0] LastIdx = SlotW'(ActiveButtons - 1);
   localparam logic [Slots-1:0] OneBit = Slots'(1);

   bge_pkg::seq_state_type state_ff, state_in;
   logic [SlotW-1:0] idx_ff, idx_in;
   logic [1:0] ph_ff, ph_in;
   bge_pkg::btn_state_type st_ff [Slots];
   bge_pkg::btn_state_type st_cap [Slots];
   logic [bge_pkg::TICK_W-1:0] now_ff;

   logic [Slots-1:0] long_fired_ff, long_fired_in;
   logic [Slots-1:0] repeating_ff, repeating_in;
   logic combo_active_ff, combo_active_in;
   logic lcombo_done_ff, lcombo_done_in;
   logic [bge_pkg::TICK_W-1:0] lp_stamp_ff, lp_stamp_in;
   logic [bge_pkg::TICK_W-1:0] rep_stamp_ff, rep_stamp_in;
   logic [bge_pkg::TICK_W-1:0] combo_stamp_ff, combo_stamp_in;
   logic [bge_pkg::TICK_W-1:0] dc_stamp_ff, dc_stamp_in;
   logic awaiting_ff, awaiting_in;
   logic [SlotW-1:0] first_btn_ff, first_btn_in;

   bge_pkg::btn_state_type cur;
   logic [bge_pkg::FEAT_W-1:0] en;
   logic combo_any;
   logic [Slots-1:0] down_mask;
   logic held_any;
   logic multi_down;
   logic other_down;
   logic accept;
   logic emit_want;
   bge_pkg::bge_event_type ev;
   logic last_ph;
   logic brk;
   logic stall;
   logic do_step;

   logic [bge_pkg::TICK_W-1:0] tmr_stamp;
   logic [bge_pkg::THR_W-1:0] tmr_thr;
   bge_pkg::cmp_op_type tmr_op;
   logic tmr_hit;

   // button states of the poll, slots past the button count read as idle
   always_comb begin
      for (int j = 0; j < Slots; j++) begin
         st_cap[j] = (j < ActiveButtons) ?
            bge_pkg::btn_state_type'(req_ch.button_states[2*j +: 2]) : bge_pkg::BTN_IDLE;
      end
   end

   // poll-wide summaries
   always_comb begin
      held_any = 1'b0;
      for (int j = 0; j < Slots; j++) begin
         down_mask[j] = (st_ff[j] == bge_pkg::BTN_PRESSING) || (st_ff[j] == bge_pkg::BTN_HELD);
         if (st_ff[j] == bge_pkg::BTN_HELD) held_any = 1'b1;
      end
   end

   assign multi_down = |(down_mask & (down_mask - Slots'(1)));
   assign other_down = |(down_mask & ~(OneBit << idx_ff));
   assign cur = st_ff[idx_ff];
   assign en = cfg.feature_enables;
   assign combo_any = en[bge_pkg::FE_COMBO] || en[bge_pkg::FE_LCOMBO];

   // shared elapsed-time compare, operands picked by button state and phase
   always_comb begin
      tmr_stamp = dc_stamp_ff;
      tmr_thr = cfg.double_click_ticks;
      tmr_op = bge_pkg::CMP_LT;
      if (cur == bge_pkg::BTN_HELD) begin
         case (ph_ff)
            2'd0: begin
               tmr_stamp = lp_stamp_ff;
               tmr_thr = cfg.long_press_ticks;
               tmr_op = bge_pkg::CMP_GE;
            end
            2'd1: begin
               tmr_stamp = combo_stamp_ff;
               tmr_thr = cfg.long_press_ticks;
               tmr_op = bge_pkg::CMP_GE;
            end
            default: begin
               tmr_stamp = rep_stamp_ff;
               tmr_thr = repeating_ff[idx_ff] ? cfg.repeat_period_ticks
                                              : cfg.repeat_first_ticks;
               tmr_op = bge_pkg::CMP_GT;
            end
         endcase
      end
   end

   bge_tmr u_tmr (
      .now   (now_ff),
      .stamp (tmr_stamp),
      .thr   (tmr_thr),
      .op    (tmr_op),
      .hit   (tmr_hit)
   );

   // one step of the current button: state updates and at most one event
   always_comb begin
      long_fired_in = long_fired_ff;
      repeating_in = repeating_ff;
      combo_active_in = combo_active_ff;
      lcombo_done_in = lcombo_done_ff;
      lp_stamp_in = lp_stamp_ff;
      rep_stamp_in = rep_stamp_ff;
      combo_stamp_in = combo_stamp_ff;
      dc_stamp_in = dc_stamp_ff;
      awaiting_in = awaiting_ff;
      first_btn_in = first_btn_ff;
      emit_want = 1'b0;
      ev.kind = bge_pkg::EV_SHORT;
      ev.button = idx_ff;
      ev.mask = '0;
      last_ph = 1'b1;
      brk = 1'b0;
      unique case (cur)
         bge_pkg::BTN_PRESSING: begin
            if (en[bge_pkg::FE_LONG]) long_fired_in[idx_ff] = 1'b0;
            if (en[bge_pkg::FE_REPEAT]) repeating_in[idx_ff] = 1'b0;
            if (combo_any && multi_down) begin
               // several buttons down: combo instead of single press
               combo_active_in = 1'b1;
               if (en[bge_pkg::FE_COMBO]) begin
                  emit_want = 1'b1;
                  ev.kind = bge_pkg::EV_COMBO;
                  ev.mask = down_mask;
               end
               if (en[bge_pkg::FE_LCOMBO]) combo_stamp_in = now_ff;
            end else begin
               if (combo_any) combo_active_in = other_down;
               if (en[bge_pkg::FE_DOUBLE]) begin
                  emit_want = 1'b1;
                  if (awaiting_ff && (first_btn_ff == idx_ff) && tmr_hit) begin
                     ev.kind = bge_pkg::EV_DOUBLE;
                     awaiting_in = 1'b0;
                  end else begin
                     ev.kind = bge_pkg::EV_SHORT;
                     awaiting_in = 1'b1;
                     dc_stamp_in = now_ff;
                     first_btn_in = idx_ff;
                  end
               end
               if (en[bge_pkg::FE_SHORT] && !en[bge_pkg::FE_DOUBLE] && !en[bge_pkg::FE_LONG]) begin
                  emit_want = 1'b1;
                  ev.kind = bge_pkg::EV_SHORT;
               end
               if (en[bge_pkg::FE_LONG]) lp_stamp_in = now_ff;
               if (en[bge_pkg::FE_REPEAT]) rep_stamp_in = now_ff;
            end
         end
         bge_pkg::BTN_RELEASING: begin
            last_ph = (ph_ff == 2'd1);
            if (ph_ff == 2'd0) begin
               if (combo_any && combo_active_ff) begin
                  // combo release ends the poll
                  combo_active_in = held_any;
                  if (en[bge_pkg::FE_LCOMBO] && !held_any) lcombo_done_in = 1'b0;
                  brk = 1'b1;
               end else if (en[bge_pkg::FE_RELEASE]) begin
                  emit_want = 1'b1;
                  ev.kind = bge_pkg::EV_RELEASE;
               end
            end else if (en[bge_pkg::FE_SHORT] && en[bge_pkg::FE_LONG] &&
                         !long_fired_ff[idx_ff]) begin
               emit_want = 1'b1;
               ev.kind = bge_pkg::EV_SHORT;
            end
         end
         bge_pkg::BTN_HELD: begin
            last_ph = (ph_ff == 2'd2);
            case (ph_ff)
               2'd0: begin
                  if (en[bge_pkg::FE_LONG] && !long_fired_ff[idx_ff] &&
                      !(combo_any && combo_active_ff) && tmr_hit) begin
                     long_fired_in[idx_ff] = 1'b1;
                     emit_want = 1'b1;
                     ev.kind = bge_pkg::EV_LONG;
                  end
               end
               2'd1: begin
                  if (en[bge_pkg::FE_LCOMBO] && combo_active_ff && !lcombo_done_ff &&
                      tmr_hit) begin
                     lcombo_done_in = 1'b1;
                     emit_want = 1'b1;
                     ev.kind = bge_pkg::EV_LCOMBO;
                     ev.mask = down_mask;
                  end
               end
               default: begin
                  if (en[bge_pkg::FE_REPEAT] && tmr_hit) begin
                     rep_stamp_in = now_ff;
                     repeating_in[idx_ff] = 1'b1;
                     emit_want = 1'b1;
                     ev.kind = bge_pkg::EV_REPEAT;
                  end
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      ph_in = ph_ff;
      unique case (state_ff)
         bge_pkg::SEQ_IDLE: begin
            if (req_ch.valid) begin
               state_in = bge_pkg::SEQ_SCAN;
               idx_in = '0;
               ph_in = '0;
            end
         end
         bge_pkg::SEQ_SCAN: begin
            if (!stall) begin
               if (brk || (last_ph && (idx_ff == LastIdx))) begin
                  state_in = bge_pkg::SEQ_FLUSH;
               end else if (last_ph) begin
                  idx_in = idx_ff + SlotW'(1);
                  ph_in = '0;
               end else begin
                  ph_in = ph_ff + 2'd1;
               end
            end
         end
         bge_pkg::SEQ_FLUSH: begin
            if (grant) state_in = bge_pkg::SEQ_IDLE;
         end
         default: state_in = bge_pkg::SEQ_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      accept = 1'b0;
      stall = 1'b0;
      do_step = 1'b0;
      emit.push = 1'b0;
      emit.finish = 1'b0;
      emit.ev = ev;
      unique case (state_ff)
         bge_pkg::SEQ_IDLE: accept = req_ch.valid;
         bge_pkg::SEQ_SCAN: begin
            emit.push = emit_want;
            stall = emit_want && !grant;
            do_step = !stall;
         end
         bge_pkg::SEQ_FLUSH: emit.finish = 1'b1;
         default: begin
         end
      endcase
   end

   assign req_ch.ready = (state_ff == bge_pkg::SEQ_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bge_pkg::SEQ_IDLE;
         idx_ff <= '0;
         ph_ff <= '0;
         long_fired_ff <= '0;
         repeating_ff <= '0;
         combo_active_ff <= 1'b0;
         lcombo_done_ff <= 1'b0;
         lp_stamp_ff <= '0;
         rep_stamp_ff <= '0;
         combo_stamp_ff <= '0;
         dc_stamp_ff <= '0;
         awaiting_ff <= 1'b0;
         first_btn_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         ph_ff <= ph_in;
         if (do_step) begin
            long_fired_ff <= long_fired_in;
            repeating_ff <= repeating_in;
            combo_active_ff <= combo_active_in;
            lcombo_done_ff <= lcombo_done_in;
            lp_stamp_ff <= lp_stamp_in;
            rep_stamp_ff <= rep_stamp_in;
            combo_stamp_ff <= combo_stamp_in;
            dc_stamp_ff <= dc_stamp_in;
            awaiting_ff <= awaiting_in;
            first_btn_ff <= first_btn_in;
         end
      end
   end

   // poll capture
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int j = 0; j < Slots; j++) st_ff[j] <= st_cap[j];
         now_ff <= req_ch.now_ticks;
      end
   end

endmodule

[design/button_gesture_event_generator.sv]
// Button gesture event generator.
// req_ch carries one poll per beat: 2 bits of debounced state per button and
// the poll's tick stamp. rsp_ch carries gesture events (kind, button, combo
// mask); last_of_poll marks the final event of a poll, and a poll with no
// event yields no beat. The csr_ port writes the feature enables and the
// tick thresholds, one register per cycle with csr_we high.
// The sequencer visits the buttons in order, one step per cycle unless
// rsp_ch stalls, all timing tests sharing one 32-bit elapsed-time compare:
// an idle or pressing button takes 1 step, a releasing one 2, a held one 3.
// A combo release ends the scan early; req_ch.ready is high only
// between polls. Each event is held back until the next event or the end
// of the poll so that the last one can be marked.
// When rsp_ch stalls, the sequencer waits at the step that wants to emit;
// the next poll is accepted as soon as the last event sits in the output
// register. Reset clears all gesture state and stamps, loads the register
// defaults and leaves the block ready.
module button_gesture_event_generator #(
   parameter int NUM_BUTTONS = bge_pkg::NUM_BUTTONS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   bge_req_if.sink                           req_ch,
   bge_rsp_if.source                         rsp_ch,
   input  logic                              csr_we,
   input  logic [bge_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bge_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   bge_pkg::bge_cfg_type cfg_ff, cfg_in;
   bge_pkg::bge_emit_type emit;
   logic grant;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            bge_pkg::CSR_FEATURES:
               cfg_in.feature_enables = csr_wdata[bge_pkg::FEAT_W-1:0];
            bge_pkg::CSR_LONG_PRESS:     cfg_in.long_press_ticks = csr_wdata;
            bge_pkg::CSR_REPEAT_FIRST:   cfg_in.repeat_first_ticks = csr_wdata;
            bge_pkg::CSR_REPEAT_PERIOD:  cfg_in.repeat_period_ticks = csr_wdata;
            bge_pkg::CSR_DOUBLE_CLICK:   cfg_in.double_click_ticks = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.feature_enables <= bge_pkg::FEATURES_RST;
         cfg_ff.long_press_ticks <= bge_pkg::LONG_PRESS_RST;
         cfg_ff.repeat_first_ticks <= bge_pkg::REPEAT_FIRST_RST;
         cfg_ff.repeat_period_ticks <= bge_pkg::REPEAT_PERIOD_RST;
         cfg_ff.double_click_ticks <= bge_pkg::DOUBLE_CLICK_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bge_seq #(
      .NUM_BUTTONS (NUM_BUTTONS)
   ) u_seq (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .req_ch (req_ch),
      .grant  (grant),
      .emit   (emit)
   );

   bge_out u_out (
      .clock  (clock),
      .reset  (reset),
      .emit   (emit),
      .grant  (grant),
      .rsp_ch (rsp_ch)
   );

endmodule
